[rtl/its_pkg.sv]
// Shared types and constants for the interval timing statistics block.
`default_nettype none
package its_pkg;

   localparam int ID_W    = 6;
   localparam int TS_W    = 64;
   localparam int LCNT_W  = 16;
   localparam int TCNT_W  = 32;
   localparam int BATCH_W = 16;

   localparam int NUM_FUNCS_DEF = 64;
   localparam logic [BATCH_W-1:0] BATCH_RESET = 16'd1000;
   localparam logic [LCNT_W-1:0]  LCNT_MAX    = '1;
   localparam logic [TCNT_W-1:0]  TCNT_MAX    = '1;

   // one table entry: interval state, local batch record, global record
   typedef struct packed {
      logic              open;
      logic [TS_W-1:0]   start;
      logic [TS_W-1:0]   lmin;
      logic [TS_W-1:0]   lmax;
      logic [TS_W-1:0]   lsum;
      logic [LCNT_W-1:0] lcnt;
      logic [TS_W-1:0]   tmin;
      logic [TS_W-1:0]   tmax;
      logic [TS_W-1:0]   tsum;
      logic [TCNT_W-1:0] tcnt;
   } rec_type;

   // controller to datapath
   typedef struct packed {
      logic clr;      // write zero entry, step clear pointer
      logic cap;      // latch request
      logic rd;       // table read
      logic elapse;   // register elapsed ticks
      logic lcl;      // register updated local record
      logic mrg;      // register merged global record
      logic wr;       // write entry back, load response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic in_range;
      logic is_open;
      logic wr_stall;
   } sts_type;

endpackage
`default_nettype wire

[rtl/its_ctrl.sv]
// Sequencing state machine for the interval timing statistics block.
`default_nettype none
module its_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire its_pkg::sts_type sts,
   output its_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_ELAPSE = 3'd3;
   localparam logic [2:0] ST_LOCAL  = 3'd4;
   localparam logic [2:0] ST_MERGE  = 3'd5;
   localparam logic [2:0] ST_WRITE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // out-of-range ids are dropped here
            if (sts.in_range) begin
               cmd.rd   = 1'b1;
               state_in = ST_ELAPSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ELAPSE: begin
            cmd.elapse = 1'b1;
            state_in   = sts.is_open ? ST_LOCAL : ST_WRITE;
         end
         ST_LOCAL: begin
            cmd.lcl  = 1'b1;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.mrg  = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!sts.wr_stall) begin
               cmd.wr   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

[rtl/its_dpath.sv]
// Table memory, interval arithmetic and response register.
`default_nettype none
module its_dpath #(
   parameter int NUM_FUNCS = its_pkg::NUM_FUNCS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire its_pkg::cmd_type            cmd,
   output its_pkg::sts_type                 sts,
   input  wire [its_pkg::ID_W-1:0]          req_func_id,
   input  wire [its_pkg::TS_W-1:0]          req_timestamp,
   input  wire                              csr_wr_en,
   input  wire [its_pkg::BATCH_W-1:0]       csr_wr_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [its_pkg::ID_W-1:0]         rsp_report_id,
   output logic [its_pkg::TS_W-1:0]         rsp_global_min,
   output logic [its_pkg::TS_W-1:0]         rsp_global_max,
   output logic [its_pkg::TS_W-1:0]         rsp_global_sum,
   output logic [its_pkg::TCNT_W-1:0]       rsp_global_count
);

   localparam int IDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FUNCS - 1);

   its_pkg::rec_type mem [NUM_FUNCS];
   its_pkg::rec_type rd_ff;
   its_pkg::rec_type wr_rec;
   logic [IDX_W-1:0] wr_addr;

   logic [IDX_W-1:0]               clr_ff;
   logic [its_pkg::BATCH_W-1:0]    batch_ff;
   logic [its_pkg::ID_W-1:0]       id_ff;
   logic [its_pkg::TS_W-1:0]       ts_ff;
   logic [IDX_W-1:0]               idx;

   logic [its_pkg::TS_W-1:0]       elapsed_ff;
   logic [its_pkg::TS_W-1:0]       lmin_ff, lmin_in;
   logic [its_pkg::TS_W-1:0]       lmax_ff, lmax_in;
   logic [its_pkg::TS_W-1:0]       lsum_ff, lsum_in;
   logic [its_pkg::LCNT_W-1:0]     lcnt_ff, lcnt_in;
   logic                           merge_ff, merge_in;
   logic [its_pkg::TS_W-1:0]       tmin_ff, tmin_in;
   logic [its_pkg::TS_W-1:0]       tmax_ff, tmax_in;
   logic [its_pkg::TS_W-1:0]       tsum_ff, tsum_in;
   logic [its_pkg::TCNT_W-1:0]     tcnt_ff, tcnt_in;
   logic [its_pkg::TCNT_W:0]       tcnt_wide;

   logic rsp_valid_ff, rsp_valid_in;
   logic emit;

   assign idx = IDX_W'(id_ff);

   // status
   assign emit = rd_ff.open && merge_ff;

   always_comb begin
      sts.clr_last = (clr_ff == LAST_IDX);
      sts.in_range = (32'(id_ff) < 32'(NUM_FUNCS));
      sts.is_open  = rd_ff.open;
      sts.wr_stall = emit && rsp_valid_ff && !rsp_ready;
   end

   // config register
   always_ff @(posedge clock) begin
      if (reset)          batch_ff <= its_pkg::BATCH_RESET;
      else if (csr_wr_en) batch_ff <= csr_wr_data;
   end

   // clear pointer
   always_ff @(posedge clock) begin
      if (reset)        clr_ff <= '0;
      else if (cmd.clr) clr_ff <= clr_ff + 1'b1;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         id_ff <= req_func_id;
         ts_ff <= req_timestamp;
      end
   end

   // local update
   always_comb begin
      lmin_in = ((rd_ff.lmin == '0) || (elapsed_ff < rd_ff.lmin)) ? elapsed_ff : rd_ff.lmin;
      lmax_in = (elapsed_ff > rd_ff.lmax) ? elapsed_ff : rd_ff.lmax;
      lsum_in = rd_ff.lsum + elapsed_ff;
      lcnt_in = (rd_ff.lcnt == its_pkg::LCNT_MAX) ? rd_ff.lcnt : rd_ff.lcnt + 1'b1;
      merge_in = (lcnt_in >= batch_ff);
   end

   // global merge
   always_comb begin
      tmin_in   = ((rd_ff.tmin == '0) || (rd_ff.tmin > lmin_ff)) ? lmin_ff : rd_ff.tmin;
      tmax_in   = (rd_ff.tmax < lmax_ff) ? lmax_ff : rd_ff.tmax;
      tsum_in   = rd_ff.tsum + lsum_ff;
      tcnt_wide = {1'b0, rd_ff.tcnt} + (its_pkg::TCNT_W + 1)'(lcnt_ff);
      tcnt_in   = tcnt_wide[its_pkg::TCNT_W] ? its_pkg::TCNT_MAX
                                             : tcnt_wide[its_pkg::TCNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.elapse) elapsed_ff <= ts_ff - rd_ff.start;
      if (cmd.lcl) begin
         lmin_ff  <= lmin_in;
         lmax_ff  <= lmax_in;
         lsum_ff  <= lsum_in;
         lcnt_ff  <= lcnt_in;
      end
      if (cmd.mrg) begin
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         tsum_ff <= tsum_in;
         tcnt_ff <= tcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)        merge_ff <= 1'b0;
      else if (cmd.lcl) merge_ff <= merge_in;
   end

   // write-back entry
   always_comb begin
      wr_rec = rd_ff;
      if (!rd_ff.open) begin
         wr_rec.open  = 1'b1;
         wr_rec.start = ts_ff;
      end else begin
         wr_rec.open = 1'b0;
         if (merge_ff) begin
            wr_rec.lmin = '0;
            wr_rec.lmax = '0;
            wr_rec.lsum = '0;
            wr_rec.lcnt = '0;
            wr_rec.tmin = tmin_ff;
            wr_rec.tmax = tmax_ff;
            wr_rec.tsum = tsum_ff;
            wr_rec.tcnt = tcnt_ff;
         end else begin
            wr_rec.lmin = lmin_ff;
            wr_rec.lmax = lmax_ff;
            wr_rec.lsum = lsum_ff;
            wr_rec.lcnt = lcnt_ff;
         end
      end
      if (cmd.clr) wr_rec = '0;
   end

   assign wr_addr = cmd.clr ? clr_ff : idx;

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr || cmd.wr) mem[wr_addr] <= wr_rec;
      if (cmd.rd)            rd_ff <= mem[idx];
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.wr && emit)  rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr && emit) begin
         rsp_report_id    <= id_ff;
         rsp_global_min   <= tmin_ff;
         rsp_global_max   <= tmax_ff;
         rsp_global_sum   <= tsum_ff;
         rsp_global_count <= tcnt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/interval_timing_stats_core.sv]
// Top level of the per-function interval timing statistics block.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+-----------
//  request  | req_valid/req_ready, func_id, timestamp | in
//  response | rsp_valid/rsp_ready, report_id, global_*| out
//  csr      | csr_wr_en, csr_wr_data (batch_size)     | in
//
// One request at a time, by stepwise table read-modify-write: a closing
// request holds the block from the accepting cycle through write-back
// (read, elapsed subtract, local update, global merge, write); an opening
// request skips local update and merge; an id at or above NUM_FUNCS is
// dropped at the read. After reset the table is swept to zero, one entry
// per cycle, with req_ready low; csr writes are taken throughout. A
// response waits in its output register; the block keeps working and holds
// a write-back that emits a response only while an earlier one is untaken.
`default_nettype none
module interval_timing_stats_core #(
   parameter int NUM_FUNCS = its_pkg::NUM_FUNCS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [its_pkg::ID_W-1:0]          req_func_id,
   input  wire [its_pkg::TS_W-1:0]          req_timestamp,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [its_pkg::ID_W-1:0]         rsp_report_id,
   output logic [its_pkg::TS_W-1:0]         rsp_global_min,
   output logic [its_pkg::TS_W-1:0]         rsp_global_max,
   output logic [its_pkg::TS_W-1:0]         rsp_global_sum,
   output logic [its_pkg::TCNT_W-1:0]       rsp_global_count,
   input  wire                              csr_wr_en,
   input  wire [its_pkg::BATCH_W-1:0]       csr_wr_data
);

   its_pkg::cmd_type cmd;
   its_pkg::sts_type sts;

   // sequencer: clear sweep, then one request per pass
   its_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, arithmetic, batch register, response register
   its_dpath #(
      .NUM_FUNCS (NUM_FUNCS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func_id      (req_func_id),
      .req_timestamp    (req_timestamp),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_report_id    (rsp_report_id),
      .rsp_global_min   (rsp_global_min),
      .rsp_global_max   (rsp_global_max),
      .rsp_global_sum   (rsp_global_sum),
      .rsp_global_count (rsp_global_count)
   );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for interval_timing_stats_core: per-function interval statistics.
module tb_top;
   import its_pkg::*;

   // Table depth used by the DUT instance (parameter left at its default).
   localparam int N_FUNCS = NUM_FUNCS_DEF;
   // Longest request is a closing event, from accept through write-back.
   // SETTLE_CYCLES covers it before touching the csr or ending the run.
   localparam int SETTLE_CYCLES = 12;
   // Upper bound on the final wait for outstanding responses.
   localparam int DRAIN_LIMIT = 20000;

   // One expected response: the global record of one function after a merge.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TS_W-1:0]   min_ticks;
      logic [TS_W-1:0]   max_ticks;
      logic [TS_W-1:0]   sum_ticks;
      logic [TCNT_W-1:0] count;
   } stats_report_type;

   // Clock, reset and DUT ports; every input has a known value from time 0.
   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [ID_W-1:0]     req_func_id   = '0;
   logic [TS_W-1:0]     req_timestamp = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [ID_W-1:0]     rsp_report_id;
   logic [TS_W-1:0]     rsp_global_min;
   logic [TS_W-1:0]     rsp_global_max;
   logic [TS_W-1:0]     rsp_global_sum;
   logic [TCNT_W-1:0]   rsp_global_count;
   logic                csr_wr_en     = 1'b0;
   logic [BATCH_W-1:0]  csr_wr_data   = '0;

   // Shadow of the DUT tables. 2-state, so everything starts at zero like
   // the post-reset sweep.
   bit                  probe_open  [N_FUNCS];
   bit [TS_W-1:0]       probe_start [N_FUNCS];
   bit [TS_W-1:0]       batch_min   [N_FUNCS];   // 0 = unset
   bit [TS_W-1:0]       batch_max   [N_FUNCS];
   bit [TS_W-1:0]       batch_sum   [N_FUNCS];
   bit [LCNT_W-1:0]     batch_cnt   [N_FUNCS];
   bit [TS_W-1:0]       agg_min     [N_FUNCS];   // 0 = unset
   bit [TS_W-1:0]       agg_max     [N_FUNCS];
   bit [TS_W-1:0]       agg_sum     [N_FUNCS];
   bit [TCNT_W-1:0]     agg_cnt     [N_FUNCS];
   bit [BATCH_W-1:0]    batch_limit = BATCH_RESET;

   stats_report_type    expected_reports [$];
   int                  mismatch_count = 0;
   int                  send_idle_pct  = 0;
   int                  recv_idle_pct  = 0;

   interval_timing_stats_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func_id      (req_func_id),
      .req_timestamp    (req_timestamp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_report_id    (rsp_report_id),
      .rsp_global_min   (rsp_global_min),
      .rsp_global_max   (rsp_global_max),
      .rsp_global_sum   (rsp_global_sum),
      .rsp_global_count (rsp_global_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: fold one accepted probe event into the shadow tables.
   // Returns 1 and fills rpt when the event triggers a merge.
   // ---------------------------------------------------------------------
   function automatic bit fold_event(input logic [ID_W-1:0] id,
                                     input logic [TS_W-1:0] ts,
                                     output stats_report_type rpt);
      logic [TS_W-1:0]   ticks;
      logic [TCNT_W:0]   cnt_sum;
      rpt = '0;
      if (int'(id) >= N_FUNCS)
         return 1'b0;
      // opening event: remember when it started
      if (!probe_open[id]) begin
         probe_open[id]  = 1'b1;
         probe_start[id] = ts;
         return 1'b0;
      end
      probe_open[id] = 1'b0;
      ticks = ts - probe_start[id];            // wraps modulo 2^64
      // a zero interval can land in min and then reads as unset
      if (batch_min[id] == '0 || ticks < batch_min[id])
         batch_min[id] = ticks;
      if (ticks > batch_max[id])
         batch_max[id] = ticks;
      batch_sum[id] += ticks;
      if (batch_cnt[id] != LCNT_MAX)
         batch_cnt[id] += 1'b1;
      // batch of zero behaves like one; a lowered batch merges at once
      if (batch_cnt[id] < batch_limit)
         return 1'b0;
      if (agg_min[id] == '0 || agg_min[id] > batch_min[id])
         agg_min[id] = batch_min[id];
      if (agg_max[id] < batch_max[id])
         agg_max[id] = batch_max[id];
      agg_sum[id] += batch_sum[id];
      cnt_sum = {1'b0, agg_cnt[id]} + batch_cnt[id];
      agg_cnt[id] = cnt_sum[TCNT_W] ? TCNT_MAX : cnt_sum[TCNT_W-1:0];
      batch_min[id] = '0;
      batch_max[id] = '0;
      batch_sum[id] = '0;
      batch_cnt[id] = '0;
      rpt.id        = id;
      rpt.min_ticks = agg_min[id];
      rpt.max_ticks = agg_max[id];
      rpt.sum_ticks = agg_sum[id];
      rpt.count     = agg_cnt[id];
      return 1'b1;
   endfunction

   function automatic logic [TS_W-1:0] rand_ticks();
      return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------------
   // Mismatch reporting and response checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_report();
      stats_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch($sformatf("response for id %0d with none expected",
                                   rsp_report_id));
         return;
      end
      want = expected_reports.pop_front();
      if (rsp_report_id !== want.id)
         report_mismatch($sformatf("report_id %0d, want %0d", rsp_report_id, want.id));
      if (rsp_global_min !== want.min_ticks)
         report_mismatch($sformatf("id %0d global_min %0h, want %0h",
                                   want.id, rsp_global_min, want.min_ticks));
      if (rsp_global_max !== want.max_ticks)
         report_mismatch($sformatf("id %0d global_max %0h, want %0h",
                                   want.id, rsp_global_max, want.max_ticks));
      if (rsp_global_sum !== want.sum_ticks)
         report_mismatch($sformatf("id %0d global_sum %0h, want %0h",
                                   want.id, rsp_global_sum, want.sum_ticks));
      if (rsp_global_count !== want.count)
         report_mismatch($sformatf("id %0d global_count %0d, want %0d",
                                   want.id, rsp_global_count, want.count));
   endtask

   // Response side: random back-pressure, check every taken response.
   // rsp_ready/rsp_valid read here are the values from before this edge.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready)
         check_report();
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Send one probe event. Valid is only dropped when a gap is taken, so a
   // back-to-back request never sees valid lowered and raised in one step.
   task automatic send_probe(input logic [ID_W-1:0] id, input logic [TS_W-1:0] ts);
      stats_report_type rpt;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_func_id   <= id;
      req_timestamp <= ts;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge
      if (fold_event(id, ts, rpt))
         expected_reports = {expected_reports, rpt};
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
   endtask

   // Hold off requests until every expected response is back and the block
   // has had time to finish an opening request that produces none.
   task automatic wait_drained();
      release_request();
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write: one cycle of write enable; block must be idle.
   task automatic write_batch_size(input logic [BATCH_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      batch_limit  = value;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset batch of 1000: closings only accumulate locally. Includes a zero
   // interval that first sets min to 0 and is then replaced. Lowering the
   // batch below the running count makes the next closing merge.
   task automatic test_default_batch();
      send_probe(6'd5, 64'd100);
      send_probe(6'd5, 64'd100);     // zero interval
      send_probe(6'd5, 64'd200);
      send_probe(6'd5, 64'd250);
      send_probe(6'd5, 64'd300);
      send_probe(6'd5, 64'd310);
      wait_drained();
      write_batch_size(16'd2);
      send_probe(6'd5, 64'd400);
      send_probe(6'd5, 64'd407);     // count 4 >= 2: merge
   endtask

   // Batch zero merges on every closing. Timestamp extremes, interval that
   // wraps past 2^64, global sum wrap, and a zero interval clearing min.
   task automatic test_batch_zero_and_wrap();
      wait_drained();
      write_batch_size(16'd0);
      send_probe(6'd63, 64'hFFFF_FFFF_FFFF_FFF0);
      send_probe(6'd63, 64'h10);     // wraps: 0x20 ticks
      send_probe(6'd0, 64'h0);
      send_probe(6'd0, '1);          // largest interval
      send_probe(6'd0, 64'h0);
      send_probe(6'd0, '1);          // sum wraps
      send_probe(6'd0, 64'h1234);
      send_probe(6'd0, 64'h1234);    // zero interval: global min becomes 0
      send_probe(6'd0, 64'h5000);
      send_probe(6'd0, 64'h5003);    // min reads unset, replaced by 3
   endtask

   // Largest batch: nothing merges; then lower it to 1 so the next closing
   // merges the whole local record.
   task automatic test_batch_max_then_lower();
      wait_drained();
      write_batch_size(16'hFFFF);
      send_probe(6'd33, rand_ticks());
      send_probe(6'd33, probe_start[33] + 64'd9);
      send_probe(6'd33, 64'd77);
      send_probe(6'd33, 64'd79);
      wait_drained();
      write_batch_size(16'd1);
      send_probe(6'd33, 64'd1000);
      send_probe(6'd33, 64'd1500);
   endtask

   function automatic logic [BATCH_W-1:0] pick_batch();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'd2;
         3:       return 16'd3;
         4:       return 16'd5;
         default: return 16'd8;
      endcase
   endfunction

   // Mostly short intervals, some zero, some spanning the full 64 bits.
   function automatic logic [TS_W-1:0] pick_interval();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return rand_ticks();
         default: return 64'($urandom_range(1, 5000));
      endcase
   endfunction

   // Random traffic concentrated on a few hot functions so merges come
   // often, the rest spread over all ids. The batch is changed mid-phase.
   task automatic test_random_traffic(input int n_items, input int send_pct,
                                      input int recv_pct);
      logic [ID_W-1:0] hot_ids [4];
      logic [ID_W-1:0] id;
      logic [TS_W-1:0] ts;
      wait_drained();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      foreach (hot_ids[k])
         hot_ids[k] = ID_W'($urandom_range(0, N_FUNCS - 1));
      write_batch_size(pick_batch());
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) begin
            wait_drained();
            write_batch_size(pick_batch());
         end
         if ($urandom_range(0, 99) < 70)
            id = hot_ids[$urandom_range(0, 3)];
         else
            id = ID_W'($urandom_range(0, N_FUNCS - 1));
         if (probe_open[id])
            ts = probe_start[id] + pick_interval();
         else if ($urandom_range(0, 1) != 0)
            ts = rand_ticks();
         else
            ts = 64'($urandom_range(0, 100000));
         send_probe(id, ts);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int drain_wait;
      drain_wait = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed part under the first idling mix
      send_idle_pct = 26;
      recv_idle_pct = 83;
      test_default_batch();
      test_batch_zero_and_wrap();
      test_batch_max_then_lower();
      // random part: sender/receiver idling swapped, then none
      test_random_traffic(300, 26, 83);
      test_random_traffic(300, 83, 26);
      test_random_traffic(300, 0, 0);
      release_request();
      while (expected_reports.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived",
                                   expected_reports.size()));
      if (mismatch_count == 0)
         $display("interval_timing_stats_core test passed");
      else
         $display("interval_timing_stats_core test failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (~1000 requests plus the
   // reset sweep).
   initial begin
      #5000000;
      $display("interval_timing_stats_core test failed");
      $finish;
   end

endmodule
